@@ hw/rtl/a2b_pkg.sv @@
`timescale 1ns / 1ps
// a2b_pkg: shared types and constants of the AVCC to Annex-B converter.
// No dependencies.
package a2b_pkg;

    localparam int SIZE_BITS        = 20;
    localparam int MAX_PREFIX_BYTES = 4;
    localparam int MAX_RESULTS      = 5;
    localparam int RUN_CNT_BITS     = $clog2(MAX_RESULTS + 1);

    localparam logic [2:0] NAL_LEN_RESET = 3'd4;

    // START_CODE[i] is the i-th byte sent: 00 00 00 01
    localparam logic [3:0][7:0] START_CODE = {8'h01, 8'h00, 8'h00, 8'h00};

    typedef enum logic [1:0] {
        KIND_RAW    = 2'd0,
        KIND_ANNEXB = 2'd1,
        KIND_AVCC   = 2'd2
    } t_kind;

    typedef enum logic [6:0] {
        PH_DETECT      = 7'b0000001,
        PH_COLLECT     = 7'b0000010,
        PH_RAW         = 7'b0000100,
        PH_ANNEXB      = 7'b0001000,
        PH_AVC_PREFIX  = 7'b0010000,
        PH_AVC_PAYLOAD = 7'b0100000,
        PH_DROP        = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [7:0]           data_byte;
        logic [SIZE_BITS-1:0] packet_size;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       nal_start;
        t_kind      packet_kind;
        logic       last_of_run;
    } t_out_word;

    typedef struct packed {
        logic [RUN_CNT_BITS-1:0]         count;
        t_out_word [MAX_RESULTS-1:0]     word;
    } t_run;

endpackage

@@ hw/rtl/a2b_step.sv @@
`timescale 1ns / 1ps
// a2b_step: packet classification state and the per-word conversion step.
// Depends on a2b_pkg.
module a2b_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  a2b_pkg::t_in_word i_word,
    input  logic [2:0]        i_nal_len_bytes,
    output a2b_pkg::t_run     o_run
);

    localparam int SB = a2b_pkg::SIZE_BITS;

    a2b_pkg::t_phase r_phase, n_phase;
    logic [SB-1:0]   r_pos, n_pos;
    logic [SB-1:0]   r_size, n_size;
    logic [31:0]     r_buf, n_buf;
    logic [2:0]      r_cnt, n_cnt;
    logic [31:0]     r_rem, n_rem;
    logic [2:0]      r_len, n_len;

    logic [SB-1:0]   size_eff;
    logic [2:0]      len_eff;
    logic [SB-1:0]   pos_base;
    logic [SB-1:0]   next_pos;
    logic            pkt_end;
    logic [31:0]     buf_base;
    logic [2:0]      cnt_base;
    logic [31:0]     nb;
    logic [2:0]      nc;
    logic            done;
    logic [SB:0]     avail;
    logic            is_sc;
    logic            raw_start;
    logic [31:0]     rem_dec;
    logic [7:0]      b;
    a2b_pkg::t_run   run;

    function automatic a2b_pkg::t_out_word mk(input logic [7:0] v, input logic s,
                                              input a2b_pkg::t_kind k);
        a2b_pkg::t_out_word w;
        w.out_byte    = v;
        w.nal_start   = s;
        w.packet_kind = k;
        w.last_of_run = 1'b0;
        return w;
    endfunction

    always_comb begin
        b         = i_word.data_byte;
        if (r_phase == a2b_pkg::PH_DETECT) begin
            size_eff = (i_word.packet_size == '0) ? SB'(1) : i_word.packet_size;
            len_eff  = (i_nal_len_bytes > 3'(a2b_pkg::MAX_PREFIX_BYTES)) ?
                       3'(a2b_pkg::MAX_PREFIX_BYTES) : i_nal_len_bytes;
            pos_base = '0;
            buf_base = '0;
            cnt_base = '0;
        end else begin
            size_eff = r_size;
            len_eff  = r_len;
            pos_base = r_pos;
            buf_base = r_buf;
            cnt_base = r_cnt;
        end
        next_pos  = pos_base + SB'(1);
        pkt_end   = (next_pos >= size_eff) || (next_pos == '0);
        nb        = {buf_base[23:0], b};
        nc        = cnt_base + 3'd1;
        done      = nc >= len_eff;
        avail     = {1'b0, size_eff} - (SB+1)'(len_eff);
        is_sc     = ((len_eff == 3'd4) && (nb == 32'd1)) ||
                    ((len_eff == 3'd3) && (nb[23:0] == 24'd1));
        raw_start = (size_eff < SB'(4)) || (len_eff <= 3'd1);
        rem_dec   = r_rem - 32'd1;

        run     = '0;
        n_phase = r_phase;
        n_size  = size_eff;
        n_len   = len_eff;
        n_buf   = buf_base;
        n_cnt   = cnt_base;
        n_rem   = r_rem;

        unique case (r_phase)
            a2b_pkg::PH_DETECT: begin
                n_rem = '0;
                if (raw_start) begin
                    for (int i = 0; i < 4; i++) begin
                        run.word[i] = mk(a2b_pkg::START_CODE[i], i == 0, a2b_pkg::KIND_RAW);
                    end
                    run.word[4] = mk(b, 1'b0, a2b_pkg::KIND_RAW);
                    run.count   = 3'd5;
                    n_phase     = a2b_pkg::PH_RAW;
                end else begin
                    n_buf   = nb;
                    n_cnt   = nc;
                    n_phase = a2b_pkg::PH_COLLECT;
                end
            end
            a2b_pkg::PH_RAW: begin
                run.word[0] = mk(b, 1'b0, a2b_pkg::KIND_RAW);
                run.count   = 3'd1;
            end
            a2b_pkg::PH_ANNEXB: begin
                run.word[0] = mk(b, 1'b0, a2b_pkg::KIND_ANNEXB);
                run.count   = 3'd1;
            end
            a2b_pkg::PH_COLLECT: begin
                n_buf = nb;
                n_cnt = nc;
                if (done) begin
                    n_buf = '0;
                    n_cnt = '0;
                    if (is_sc) begin
                        for (int i = 0; i < 4; i++) begin
                            if (len_eff == 3'd4) begin
                                run.word[i] = mk(a2b_pkg::START_CODE[i], 1'b0,
                                                 a2b_pkg::KIND_ANNEXB);
                            end else if (i < 3) begin
                                run.word[i] = mk(a2b_pkg::START_CODE[i+1], 1'b0,
                                                 a2b_pkg::KIND_ANNEXB);
                            end
                        end
                        run.count = (len_eff == 3'd4) ? 3'd4 : 3'd3;
                        n_phase   = a2b_pkg::PH_ANNEXB;
                    end else if ((nb != '0) && (nb <= 32'(avail))) begin
                        for (int i = 0; i < 4; i++) begin
                            run.word[i] = mk(a2b_pkg::START_CODE[i], i == 0,
                                             a2b_pkg::KIND_AVCC);
                        end
                        run.count = 3'd4;
                        n_rem     = nb;
                        n_phase   = a2b_pkg::PH_AVC_PAYLOAD;
                    end else begin
                        n_phase = a2b_pkg::PH_DROP;
                    end
                end
            end
            a2b_pkg::PH_AVC_PREFIX: begin
                n_buf = nb;
                n_cnt = nc;
                if (done) begin
                    for (int i = 0; i < 4; i++) begin
                        run.word[i] = mk(a2b_pkg::START_CODE[i], i == 0, a2b_pkg::KIND_AVCC);
                    end
                    run.count = 3'd4;
                    n_rem     = nb;
                    n_buf     = '0;
                    n_cnt     = '0;
                    n_phase   = (nb != '0) ? a2b_pkg::PH_AVC_PAYLOAD
                                           : a2b_pkg::PH_AVC_PREFIX;
                end
            end
            a2b_pkg::PH_AVC_PAYLOAD: begin
                run.word[0] = mk(b, 1'b0, a2b_pkg::KIND_AVCC);
                run.count   = 3'd1;
                n_rem       = rem_dec;
                if (rem_dec == '0) begin
                    n_phase = a2b_pkg::PH_AVC_PREFIX;
                end
            end
            a2b_pkg::PH_DROP: begin
            end
            default: begin
                n_phase = a2b_pkg::PH_DETECT;
            end
        endcase

        n_pos = next_pos;
        if (pkt_end) begin
            n_phase = a2b_pkg::PH_DETECT;
        end

        for (int i = 0; i < a2b_pkg::MAX_RESULTS; i++) begin
            run.word[i].last_of_run = ((a2b_pkg::RUN_CNT_BITS'(i) + 1'b1) == run.count);
        end
    end

    assign o_run = run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= a2b_pkg::PH_DETECT;
            r_pos   <= '0;
            r_size  <= '0;
            r_buf   <= '0;
            r_cnt   <= '0;
            r_rem   <= '0;
            r_len   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_size  <= n_size;
            r_buf   <= n_buf;
            r_cnt   <= n_cnt;
            r_rem   <= n_rem;
            r_len   <= n_len;
        end
    end

endmodule

@@ hw/rtl/a2b_run_buf.sv @@
`timescale 1ns / 1ps
// a2b_run_buf: result register holding the output words of one input word,
// shifted out one per accepted output. Depends on a2b_pkg.
module a2b_run_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  a2b_pkg::t_run      i_run,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output a2b_pkg::t_out_word o_out_data,
    output logic               o_free
);

    localparam int N  = a2b_pkg::MAX_RESULTS;
    localparam int CB = a2b_pkg::RUN_CNT_BITS;

    a2b_pkg::t_out_word [N-1:0] r_ent, n_ent;
    logic [CB-1:0]              r_cnt, n_cnt;
    logic                       take;

    assign o_out_valid = r_cnt != '0;
    assign o_out_data  = r_ent[0];
    assign take        = o_out_valid && !i_out_stall;
    assign o_free      = (r_cnt == '0) || ((r_cnt == CB'(1)) && take);

    always_comb begin
        n_ent = r_ent;
        n_cnt = r_cnt;
        if (i_load) begin
            n_ent = i_run.word;
            n_cnt = i_run.count;
        end else if (take) begin
            for (int i = 0; i < N - 1; i++) begin
                n_ent[i] = r_ent[i+1];
            end
            n_cnt = r_cnt - CB'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ hw/rtl/avcc_to_annexb_converter.sv @@
`timescale 1ns / 1ps
// avcc_to_annexb_converter: top level, input register, NAL length register.
// Depends on a2b_pkg, a2b_step, a2b_run_buf.
//
// Converts a packet, fed one byte per word, into an Annex-B byte stream. The first
// bytes classify the packet: raw (start code inserted in front), already Annex-B
// (copied), or length-prefixed (each NAL length becomes 00 00 00 01); unknown packets
// and trailing partial prefixes produce nothing. Each input word yields 0 to 5 output
// words, last_of_run marking the final one. While the output is not stalled, the
// output word rate is one per cycle and an input word is taken each cycle as long as
// every word yields at most one output; a word yielding more holds the input back until
// the result buffer is down to its last word and that word is taken. An input word
// passes through the input register and then the result buffer. The NAL length
// register is sampled at the first byte of each packet; values above 4 act as 4.
// Write it only while the block is idle.
module avcc_to_annexb_converter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  a2b_pkg::t_in_word  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output a2b_pkg::t_out_word o_out_data,
    input  logic               i_out_stall,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_data
);

    a2b_pkg::t_in_word r_in;
    logic              r_in_valid, n_in_valid;
    logic [2:0]        r_nal_len;
    logic              buf_free;
    logic              move;
    logic              accept;
    a2b_pkg::t_run     run;

    assign move       = r_in_valid && buf_free;
    assign o_in_stall = r_in_valid && !move;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (move) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_nal_len  <= a2b_pkg::NAL_LEN_RESET;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_cfg_we) begin
                r_nal_len <= i_cfg_data;
            end
        end
    end

    a2b_step u_step (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (move),
        .i_word          (r_in),
        .i_nal_len_bytes (r_nal_len),
        .o_run           (run)
    );

    a2b_run_buf u_run_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (move),
        .i_run       (run),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_free      (buf_free)
    );

endmodule

@@ tb/avcc_to_annexb_converter_test.sv @@
`timescale 1ns / 1ps
// avcc_to_annexb_converter_test: self-checking bench for the AVCC to Annex-B converter.
// Depends on a2b_pkg and avcc_to_annexb_converter; predicts every output word per input byte.
module avcc_to_annexb_converter_test;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned REPORT_MAX  = 10;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    a2b_pkg::t_in_word  in_word   = '0;
    logic               in_stall;
    logic               out_valid;
    a2b_pkg::t_out_word out_word;
    logic               out_stall = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [2:0]         cfg_data  = 3'd0;

    // converter model state
    logic [2:0]      nal_len_reg   = a2b_pkg::NAL_LEN_RESET;
    a2b_pkg::t_phase cur_phase     = a2b_pkg::PH_DETECT;
    logic [19:0]     pkt_pos       = '0;
    logic [19:0]     pkt_size      = '0;
    logic [31:0]     len_buf       = '0;
    logic [2:0]      len_count     = '0;
    logic [31:0]     nal_left      = '0;
    logic [2:0]      pkt_len_bytes = '0;

    a2b_pkg::t_in_word  pend_words[$];
    a2b_pkg::t_out_word expected_words[$];
    a2b_pkg::t_out_word step_words[$];
    logic [7:0]         pkt_bytes[$];

    int unsigned words_queued = 0;
    int unsigned words_taken  = 0;
    int unsigned outs_seen    = 0;
    int unsigned errors       = 0;
    int unsigned cycle_count  = 0;
    int unsigned hold_left    = 0;
    logic        hold_done    = 1'b0;
    logic        in_took      = 1'b0;

    avcc_to_annexb_converter uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_word),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_word),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic bit calm_stretch();
        return outs_seen >= 160 && outs_seen < 280;
    endfunction

    task automatic emit(input logic [7:0] b, input logic s, input a2b_pkg::t_kind k);
        a2b_pkg::t_out_word o;
        o.out_byte    = b;
        o.nal_start   = s;
        o.packet_kind = k;
        o.last_of_run = 1'b0;
        step_words = {step_words, o};
    endtask

    task automatic emit_start_code(input a2b_pkg::t_kind k);
        int i;
        for (i = 0; i < 4; i++) begin
            emit(a2b_pkg::START_CODE[i], i == 0, k);
        end
    endtask

    // all output words caused by one accepted input word
    task automatic convert_byte(input a2b_pkg::t_in_word w);
        logic [31:0]        len;
        logic [31:0]        shifted;
        logic               is_sc;
        a2b_pkg::t_out_word o;
        int                 k;
        step_words.delete();
        if (cur_phase == a2b_pkg::PH_DETECT) begin
            pkt_size  = (w.packet_size != '0) ? w.packet_size : 20'd1;
            pkt_pos   = '0;
            len_buf   = '0;
            len_count = '0;
            nal_left  = '0;
            pkt_len_bytes = (nal_len_reg > 3'd4) ? 3'd4 : nal_len_reg;
            if (pkt_size < 20'd4 || pkt_len_bytes <= 3'd1) begin
                emit_start_code(a2b_pkg::KIND_RAW);
                cur_phase = a2b_pkg::PH_RAW;
            end else begin
                cur_phase = a2b_pkg::PH_COLLECT;
            end
        end else if (cur_phase == a2b_pkg::PH_RAW) begin
            emit(w.data_byte, 1'b0, a2b_pkg::KIND_RAW);
        end
        len = {29'd0, pkt_len_bytes};

        case (cur_phase)
            a2b_pkg::PH_RAW: begin
                if (step_words.size() == 4) emit(w.data_byte, 1'b0, a2b_pkg::KIND_RAW);
            end
            a2b_pkg::PH_ANNEXB: begin
                emit(w.data_byte, 1'b0, a2b_pkg::KIND_ANNEXB);
            end
            a2b_pkg::PH_COLLECT: begin
                len_buf   = {len_buf[23:0], w.data_byte};
                len_count = len_count + 3'd1;
                if ({29'd0, len_count} >= len) begin
                    is_sc = (len == 32'd4 && len_buf == 32'd1) ||
                            (len == 32'd3 && len_buf[23:0] == 24'd1);
                    if (is_sc) begin
                        for (k = 0; k < len; k++) begin
                            shifted = len_buf >> (8 * (len - 1 - k));
                            emit(shifted[7:0], 1'b0, a2b_pkg::KIND_ANNEXB);
                        end
                        cur_phase = a2b_pkg::PH_ANNEXB;
                    end else if (len_buf != '0 && len_buf <= {12'd0, pkt_size} - len) begin
                        emit_start_code(a2b_pkg::KIND_AVCC);
                        nal_left  = len_buf;
                        cur_phase = a2b_pkg::PH_AVC_PAYLOAD;
                    end else begin
                        cur_phase = a2b_pkg::PH_DROP;
                    end
                    len_buf   = '0;
                    len_count = '0;
                end
            end
            a2b_pkg::PH_AVC_PREFIX: begin
                len_buf   = {len_buf[23:0], w.data_byte};
                len_count = len_count + 3'd1;
                if ({29'd0, len_count} >= len) begin
                    emit_start_code(a2b_pkg::KIND_AVCC);
                    nal_left = len_buf;
                    if (nal_left != '0) begin
                        cur_phase = a2b_pkg::PH_AVC_PAYLOAD;
                    end else begin
                        cur_phase = a2b_pkg::PH_AVC_PREFIX;
                    end
                    len_buf   = '0;
                    len_count = '0;
                end
            end
            a2b_pkg::PH_AVC_PAYLOAD: begin
                emit(w.data_byte, 1'b0, a2b_pkg::KIND_AVCC);
                nal_left = nal_left - 32'd1;
                if (nal_left == '0) cur_phase = a2b_pkg::PH_AVC_PREFIX;
            end
            default: begin
            end
        endcase

        pkt_pos = pkt_pos + 20'd1;
        if (pkt_pos >= pkt_size || pkt_pos == '0) cur_phase = a2b_pkg::PH_DETECT;

        for (k = 0; k < step_words.size(); k++) begin
            o = step_words[k];
            o.last_of_run = (k == step_words.size() - 1);
            expected_words = {expected_words, o};
        end
    endtask

    task automatic add_noise(input int unsigned n);
        repeat (n) pkt_bytes = {pkt_bytes, 8'($urandom)};
    endtask

    // packet_size only matters on the first byte; later bytes carry random sizes
    task automatic queue_packet(input logic [19:0] size_field);
        a2b_pkg::t_in_word w;
        int                i;
        for (i = 0; i < pkt_bytes.size(); i++) begin
            w.data_byte   = pkt_bytes[i];
            w.packet_size = (i == 0) ? size_field : 20'($urandom);
            pend_words = {pend_words, w};
            words_queued++;
        end
    endtask

    task automatic fill_phase(input int unsigned target);
        int unsigned first;
        int unsigned pick;
        int unsigned L;
        int unsigned nals;
        int unsigned plen;
        int unsigned field;
        int unsigned i;
        int unsigned k;
        logic [19:0] size_field;
        first = words_queued;
        if (nal_len_reg > 3'd4) L = 4;
        else L = nal_len_reg;
        while (words_queued - first < target) begin
            pkt_bytes.delete();
            pick = $urandom_range(99);
            if (L >= 2 && pick < 55) begin
                nals = $urandom_range(1, 3);
                for (i = 0; i < nals; i++) begin
                    if ($urandom_range(39) == 0) plen = $urandom_range(40, 120);
                    else plen = $urandom_range(1, 10);
                    if (i != 0 && $urandom_range(7) == 0) plen = 0;
                    field = plen;
                    // length running past the packet end
                    if (i != 0 && i == nals - 1 && $urandom_range(4) == 0)
                        field = plen + $urandom_range(1, 200);
                    for (k = L; k > 0; k--) pkt_bytes = {pkt_bytes, 8'(field >> (8 * (k - 1)))};
                    add_noise(plen);
                end
                // trailing partial prefix
                if ($urandom_range(7) == 0) add_noise($urandom_range(1, L - 1));
            end else if (pick < 70) begin
                if ($urandom_range(1) == 0) pkt_bytes = '{8'h00, 8'h00, 8'h01};
                else pkt_bytes = '{8'h00, 8'h00, 8'h00, 8'h01};
                add_noise($urandom_range(1, 12));
            end else if (pick < 82) begin
                add_noise($urandom_range(1, 3));
            end else begin
                if ($urandom_range(1) == 0) begin
                    pkt_bytes = '{8'h00, 8'h00};
                    pkt_bytes = {pkt_bytes, 8'($urandom_range(2, 255))};
                end
                add_noise($urandom_range(1, 16));
            end
            size_field = 20'(pkt_bytes.size());
            if (pkt_bytes.size() == 1 && $urandom_range(1) == 0) size_field = '0;
            queue_packet(size_field);
        end
    endtask

    task automatic settle(input int unsigned tail);
        @(negedge clk);
        while (words_taken != words_queued || expected_words.size() != 0) @(negedge clk);
        repeat (tail) @(negedge clk);
    endtask

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_took) begin
            if (pend_words.size() != 0 && (calm_stretch() || $urandom_range(99) >= 33)) begin
                in_word  <= pend_words.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        in_took <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall) begin
            convert_byte(in_word);
            words_taken++;
        end
    end

    // one long hold-off lets the converter back up into its input
    always @(negedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && outs_seen >= 100) begin
            hold_done <= 1'b1;
            hold_left <= 300;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !calm_stretch() && ($urandom_range(99) < 33);
        end
    end

    always @(posedge clk) begin : check
        a2b_pkg::t_out_word want;
        if (rst_n && out_valid && !out_stall) begin
            outs_seen++;
            if (expected_words.size() == 0) begin
                if (errors < REPORT_MAX)
                    $display("unexpected word %0d: byte %02h start %0b kind %0d last %0b",
                             outs_seen, out_word.out_byte, out_word.nal_start,
                             out_word.packet_kind, out_word.last_of_run);
                errors++;
            end else begin
                want = expected_words.pop_front();
                if (out_word.out_byte !== want.out_byte ||
                    out_word.nal_start !== want.nal_start ||
                    out_word.packet_kind !== want.packet_kind ||
                    out_word.last_of_run !== want.last_of_run) begin
                    if (errors < REPORT_MAX)
                        $display("word %0d mismatch: got %02h/%0b/%0d/%0b want %02h/%0b/%0d/%0b",
                                 outs_seen, out_word.out_byte, out_word.nal_start,
                                 out_word.packet_kind, out_word.last_of_run,
                                 want.out_byte, want.nal_start, want.packet_kind,
                                 want.last_of_run);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("avcc_to_annexb_converter regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        logic [2:0]  sweep [0:7];
        int unsigned s;
        sweep = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd5, 3'd7, 3'd6, 3'd4};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero size, short raw, 4-byte start code, zero-length NAL with partial
        // trailing prefix, first length too long for the packet
        pkt_bytes = '{8'hFF};
        queue_packet(20'd0);
        pkt_bytes = '{8'h00, 8'h80, 8'h7F};
        queue_packet(20'd3);
        pkt_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'hFF};
        queue_packet(20'd5);
        pkt_bytes = '{8'h00, 8'h00, 8'h00, 8'h02, 8'hAB, 8'hCD,
                      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        queue_packet(20'd12);
        pkt_bytes = '{8'h00, 8'h00, 8'h00, 8'h09, 8'h11, 8'h22};
        queue_packet(20'd6);

        fill_phase(20);
        for (s = 0; s < 8; s++) begin
            settle(8);
            cfg_data <= sweep[s];
            cfg_we   <= 1'b1;
            @(negedge clk);
            cfg_we      <= 1'b0;
            nal_len_reg = sweep[s];
            @(posedge clk);
            fill_phase(20);
        end

        settle(20);
        if (errors == 0) begin
            $display("avcc_to_annexb_converter regression: pass");
        end else begin
            $display("avcc_to_annexb_converter regression: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/a2b_pkg.sv
hw/rtl/a2b_step.sv
hw/rtl/a2b_run_buf.sv
hw/rtl/avcc_to_annexb_converter.sv
tb/avcc_to_annexb_converter_test.sv
